// File: hdl/lrmf_pkg.sv
// Package for the lidar ring range median filter.
// Holds the item structs, register indexes and fixed field widths.
// No dependencies.
package lrmf_pkg;

	localparam int COORD_W = 16;
	localparam int RING_W = 4;
	localparam int COL_W = 11;
	localparam int CFG_W = 12;
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_RING_COUNT = 1'd0;
	localparam logic [IDX_W-1:0] REG_COLUMNS = 1'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic [RING_W-1:0] ring_index;
		logic [COL_W-1:0] column_index;
		logic last_of_run;
		logic end_of_cloud;
	} result_t;

	// One window job passed from the front to the back.
	typedef struct packed {
		point_t [4:0] win;
		logic [RING_W-1:0] ring;
		logic [COL_W-1:0] col;
		logic last;
		logic eoc;
	} job_t;

endpackage

// File: hdl/lrmf_front.sv
// Front part: tracks ring and column, keeps per-ring line and head points,
// and emits one window job per cycle while the job queue has room. Depends on lrmf_pkg.
module lrmf_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lrmf_pkg::IDX_W:0] cfg_index,
	input logic [lrmf_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input lrmf_pkg::point_t in_item,
	output logic job_valid,
	output lrmf_pkg::job_t job,
	input logic job_room
);
	logic [4:0] rings_q;
	logic [11:0] cols_q;
	logic [3:0] ring_q;
	logic [10:0] col_q;
	lrmf_pkg::point_t line_q [16][4];
	lrmf_pkg::point_t head_q [16][4];
	logic busy_q;
	logic [2:0] sub_q;
	lrmf_pkg::point_t seq_q [9];
	logic [3:0] jr_q;
	logic [10:0] jc_q;
	logic jlast_q;
	logic [11:0] cols_q2;
	logic rlast_q;

	logic [4:0] rings;
	logic [11:0] cols;
	logic [3:0] r;
	logic [10:0] c;
	logic acc;
	logic [2:0] last_sub;
	logic [11:0] colw;

	always_comb begin
		rings = (rings_q == 5'd0) ? 5'd1 : (rings_q > 5'd16 ? 5'd16 : rings_q);
		cols = (cols_q < 12'd5) ? 12'd5 : (cols_q > 12'd2048 ? 12'd2048 : cols_q);
		r = ring_q;
		c = col_q;
		if ({1'b0, ring_q} >= rings || {1'b0, col_q} >= cols) begin
			r = '0;
			c = '0;
		end
		last_sub = jlast_q ? 3'd4 : 3'd0;
		colw = {1'b0, jc_q} + {9'd0, sub_q};
		if (colw >= cols_q2) colw = colw - cols_q2;
	end

	assign in_ready = !busy_q || (job_room && sub_q == last_sub);
	assign acc = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < 5; k++) job.win[k] = seq_q[4'(sub_q) + 4'(k)];
		job.ring = jr_q;
		job.col = colw[10:0];
		job.last = (sub_q == last_sub);
		job.eoc = (sub_q == last_sub) && jlast_q && rlast_q;
	end
	assign job_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rings_q <= 5'd16;
			cols_q <= 12'd1800;
			ring_q <= '0;
			col_q <= '0;
			busy_q <= 1'b0;
			sub_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 2'(lrmf_pkg::REG_RING_COUNT)) begin
				rings_q <= cfg_data[4:0];
				ring_q <= '0;
				col_q <= '0;
			end else if (cfg_index == 2'(lrmf_pkg::REG_COLUMNS)) begin
				cols_q <= cfg_data;
				ring_q <= '0;
				col_q <= '0;
			end
		end else begin
			if (busy_q && job_room) begin
				if (sub_q == last_sub) busy_q <= 1'b0;
				else sub_q <= sub_q + 3'd1;
			end
			if (acc) begin
				busy_q <= (c >= 11'd4);
				sub_q <= '0;
				if ({1'b0, r} == rings - 5'd1) begin
					ring_q <= '0;
					col_q <= ({1'b0, c} == cols - 12'd1) ? 11'd0 : c + 11'd1;
				end else begin
					ring_q <= r + 4'd1;
					col_q <= c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !cfg_we) begin
			for (int k = 0; k < 4; k++) begin
				seq_q[k] <= line_q[r][k];
				seq_q[5 + k] <= head_q[r][k];
			end
			seq_q[4] <= in_item;
			jr_q <= r;
			jc_q <= c - 11'd2;
			jlast_q <= ({1'b0, c} == cols - 12'd1);
			rlast_q <= ({1'b0, r} == rings - 5'd1);
			cols_q2 <= cols;
			if (c < 11'd4) head_q[r][c[1:0]] <= in_item;
			for (int k = 0; k < 3; k++) line_q[r][k] <= line_q[r][k + 1];
			line_q[r][3] <= in_item;
		end
	end
endmodule

// File: hdl/lrmf_fifo.sv
// Short queue of window jobs between the front and the back.
// Depends on lrmf_pkg.
module lrmf_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_room,
	input lrmf_pkg::job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output lrmf_pkg::job_t rd_data
);
	lrmf_pkg::job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign wr_room = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign wr = wr_valid && wr_room;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

// File: hdl/lrmf_back.sv
// Back part: squared norms, pairwise ranks and median selection in three
// register stages, the last being the output register. Depends on lrmf_pkg.
module lrmf_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input lrmf_pkg::job_t job,
	output logic out_valid,
	input logic out_ready,
	output lrmf_pkg::result_t out_item
);
	logic v1_s1, v2_s2, v3_s3;
	lrmf_pkg::job_t j_s1, j_s2;
	logic [31:0] sq_s1 [5][3];
	logic [33:0] d_s2 [5];
	lrmf_pkg::result_t r_s3;
	logic adv;
	logic [2:0] pick;

	assign adv = !v3_s3 || out_ready;
	assign job_ready = adv;
	assign out_valid = v3_s3;
	assign out_item = r_s3;

	always_comb begin
		pick = 3'd2;
		for (int j = 4; j >= 0; j--) begin
			logic [2:0] rank;
			rank = '0;
			for (int i = 0; i < 5; i++)
				if (d_s2[i] < d_s2[j] || (i < j && d_s2[i] == d_s2[j])) rank = rank + 3'd1;
			if (rank == 3'd2) pick = 3'(j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= job_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			j_s1 <= job;
			for (int i = 0; i < 5; i++) begin
				sq_s1[i][0] <= 32'($signed(job.win[i].pos_x) * $signed(job.win[i].pos_x));
				sq_s1[i][1] <= 32'($signed(job.win[i].pos_y) * $signed(job.win[i].pos_y));
				sq_s1[i][2] <= 32'($signed(job.win[i].pos_z) * $signed(job.win[i].pos_z));
			end
			j_s2 <= j_s1;
			for (int i = 0; i < 5; i++)
				d_s2[i] <= {2'd0, sq_s1[i][0]} + {2'd0, sq_s1[i][1]} + {2'd0, sq_s1[i][2]};
			r_s3.out_x <= j_s2.win[pick].pos_x;
			r_s3.out_y <= j_s2.win[pick].pos_y;
			r_s3.out_z <= j_s2.win[pick].pos_z;
			r_s3.ring_index <= j_s2.ring;
			r_s3.column_index <= j_s2.col;
			r_s3.last_of_run <= j_s2.last;
			r_s3.end_of_cloud <= j_s2.eoc;
		end
	end
endmodule

// File: hdl/lidar_ring_range_median_filter.sv
// Top level of the lidar ring range median filter.
// Instantiates lrmf_front, lrmf_fifo and lrmf_back; depends on lrmf_pkg.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/ready     lrmf_pkg::point_t
// out      output     out_valid/ready    lrmf_pkg::result_t
// cfg      input      cfg_we             cfg_index, cfg_data
//
// A point at a ring's last column yields five window jobs, issued in turn by
// the front's job sequencer, and the input waits until the last is queued.
// Any other point yields at most one. A job passes the back registers s1, s2
// and s3 before its result is offered.
// Reset returns positions to zero and registers to their defaults; the point
// stores are undefined.
// A stalled output freezes the back pipeline; the job queue absorbs the front.
module lidar_ring_range_median_filter (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lrmf_pkg::IDX_W:0] cfg_index,
	input logic [lrmf_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input lrmf_pkg::point_t in_item,
	output logic out_valid,
	input logic out_ready,
	output lrmf_pkg::result_t out_item
);
	logic jv, jroom, qv, qr;
	lrmf_pkg::job_t jw, jr;

	lrmf_front u_front (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid,
		.in_ready, .in_item, .job_valid(jv), .job(jw), .job_room(jroom));
	lrmf_fifo u_fifo (.clk, .arst_n, .wr_valid(jv), .wr_room(jroom), .wr_data(jw),
		.rd_valid(qv), .rd_ready(qr), .rd_data(jr));
	lrmf_back u_back (.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(jr),
		.out_valid, .out_ready, .out_item);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_eoc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.end_of_cloud |-> out_item.last_of_run)
		else $error("end of cloud without last of run");
endmodule

// File: dv/lidar_ring_range_median_filter_tb.sv
// Testbench for the lidar ring range median filter: random and directed point clouds
// are checked against a behavioral predictor of the per-ring median window.
// Depends on lrmf_pkg and lidar_ring_range_median_filter.
module lidar_ring_range_median_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = 5;
	localparam int HALF = WIN / 2;
	localparam int KEEP = WIN - 1;
	localparam int NRINGS = 16;
	localparam int MAXCOLS = 2048;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lrmf_pkg::IDX_W:0] cfg_index = '0;
	logic [lrmf_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	lrmf_pkg::point_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	lrmf_pkg::result_t out_item;

	lidar_ring_range_median_filter u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lrmf_pkg::point_t pending_points[$];
	lrmf_pkg::result_t expected_medians[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	event hold_ev;
	int errors = 0;
	longint cycles = 0;

	lrmf_pkg::point_t ring_tail[NRINGS][KEEP];
	lrmf_pkg::point_t ring_head[NRINGS][KEEP];
	int cur_ring = 0;
	int cur_col = 0;
	int rings_cfg = 16;
	int cols_cfg = 1800;

	function automatic longint range_sq(lrmf_pkg::point_t p);
		longint x, y, z;
		x = p.pos_x;
		y = p.pos_y;
		z = p.pos_z;
		return x * x + y * y + z * z;
	endfunction

	function automatic lrmf_pkg::point_t median_of(lrmf_pkg::point_t w[WIN]);
		longint d[WIN];
		int rank;
		for (int i = 0; i < WIN; i++) d[i] = range_sq(w[i]);
		for (int j = 0; j < WIN; j++) begin
			rank = 0;
			for (int i = 0; i < WIN; i++)
				if (d[i] < d[j] || (i < j && d[i] == d[j])) rank++;
			if (rank == HALF) return w[j];
		end
		return w[HALF];
	endfunction

	function automatic void predict_point(lrmf_pkg::point_t p);
		int rings, cols, r, c, last_m, col;
		lrmf_pkg::point_t seq[2 * WIN - 1];
		lrmf_pkg::point_t w[WIN];
		lrmf_pkg::point_t pick;
		lrmf_pkg::result_t res;
		rings = rings_cfg < 1 ? 1 : (rings_cfg > NRINGS ? NRINGS : rings_cfg);
		cols = cols_cfg < WIN ? WIN : (cols_cfg > MAXCOLS ? MAXCOLS : cols_cfg);
		if (cur_ring >= rings || cur_col >= cols) begin
			cur_ring = 0;
			cur_col = 0;
		end
		r = cur_ring;
		c = cur_col;
		for (int k = 0; k < KEEP; k++) begin
			seq[k] = ring_tail[r][k];
			seq[WIN + k] = ring_head[r][k];
		end
		seq[KEEP] = p;
		if (c >= KEEP) begin
			last_m = (c == cols - 1) ? HALF + KEEP : HALF;
			for (int m = HALF; m <= last_m; m++) begin
				for (int k = 0; k < WIN; k++) w[k] = seq[m - HALF + k];
				pick = median_of(w);
				col = c + m - KEEP;
				if (col >= cols) col -= cols;
				res.out_x = pick.pos_x;
				res.out_y = pick.pos_y;
				res.out_z = pick.pos_z;
				res.ring_index = r[lrmf_pkg::RING_W-1:0];
				res.column_index = col[lrmf_pkg::COL_W-1:0];
				res.last_of_run = (m == last_m);
				res.end_of_cloud = (m == last_m) && r == rings - 1 && c == cols - 1;
				expected_medians.push_back(res);
			end
		end
		if (c < KEEP) ring_head[r][c] = p;
		for (int k = 0; k + 1 < KEEP; k++) ring_tail[r][k] = ring_tail[r][k + 1];
		ring_tail[r][KEEP - 1] = p;
		r++;
		if (r >= rings) begin
			r = 0;
			c++;
			if (c >= cols) c = 0;
		end
		cur_ring = r;
		cur_col = c;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver holds off when asked, then resumes.
	always @(hold_ev) begin
		recv_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold = 1'b0;
	end

	// Driver: the accepted point is predicted at the edge it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_point(in_item);
			if (!in_valid || in_ready) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_points.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		lrmf_pkg::result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_medians.size() == 0) begin
					$error("unexpected result %p", out_item);
					errors++;
				end else begin
					e = expected_medians.pop_front();
					if (out_item.out_x !== e.out_x) begin
						$error("out_x exp %0d got %0d", e.out_x, out_item.out_x); errors++;
					end
					if (out_item.out_y !== e.out_y) begin
						$error("out_y exp %0d got %0d", e.out_y, out_item.out_y); errors++;
					end
					if (out_item.out_z !== e.out_z) begin
						$error("out_z exp %0d got %0d", e.out_z, out_item.out_z); errors++;
					end
					if (out_item.ring_index !== e.ring_index) begin
						$error("ring_index exp %0d got %0d", e.ring_index,
							out_item.ring_index);
						errors++;
					end
					if (out_item.column_index !== e.column_index) begin
						$error("column_index exp %0d got %0d", e.column_index,
							out_item.column_index);
						errors++;
					end
					if (out_item.last_of_run !== e.last_of_run) begin
						$error("last_of_run exp %0d got %0d", e.last_of_run,
							out_item.last_of_run);
						errors++;
					end
					if (out_item.end_of_cloud !== e.end_of_cloud) begin
						$error("end_of_cloud exp %0d got %0d", e.end_of_cloud,
							out_item.end_of_cloud);
						errors++;
					end
				end
			end
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_points.size() > 0 || in_valid || expected_medians.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [lrmf_pkg::IDX_W:0] idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[lrmf_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lrmf_pkg::REG_RING_COUNT) rings_cfg = value & 'h1F;
		else if (idx == lrmf_pkg::REG_COLUMNS) cols_cfg = value & 'hFFF;
		else return;
		cur_ring = 0;
		cur_col = 0;
	endtask

	function automatic lrmf_pkg::point_t rand_point(int mode);
		lrmf_pkg::point_t p;
		p.pos_x = 16'($urandom);
		p.pos_y = 16'($urandom);
		p.pos_z = 16'($urandom);
		case (mode)
			0: begin
				p.pos_x = 16'(int'($urandom_range(200)) - 100);
				p.pos_y = 16'(int'($urandom_range(200)) - 100);
				p.pos_z = 16'(int'($urandom_range(6)) - 3);
			end
			1: begin
				p.pos_x = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
				p.pos_y = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
				p.pos_z = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic queue_points(int n);
		for (int i = 0; i < n; i++) pending_points.push_back(rand_point($urandom_range(2)));
	endtask

	initial begin
		lrmf_pkg::point_t p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: two rings of five columns with extreme, equal and zero points.
		write_reg(lrmf_pkg::REG_RING_COUNT, 2);
		write_reg(lrmf_pkg::REG_COLUMNS, 5);
		for (int i = 0; i < 10; i++) begin
			p.pos_x = (i % 3 == 0) ? 16'sh8000 : 16'sh7FFF;
			p.pos_y = (i % 2) ? 16'sh8000 : 16'sh0000;
			p.pos_z = (i == 4) ? 16'sh7FFF : 16'sh0005;
			pending_points.push_back(p);
		end
		for (int i = 0; i < 10; i++) pending_points.push_back('0);
		wait_drained();
		// Out-of-range values saturate; unknown index is ignored.
		write_reg(lrmf_pkg::REG_RING_COUNT, 0);
		write_reg(lrmf_pkg::REG_COLUMNS, 2);
		write_reg(2, 7);
		queue_points(10);
		wait_drained();

		send_idle_pct = 18;
		recv_idle_pct = 64;
		write_reg(lrmf_pkg::REG_RING_COUNT, 16);
		write_reg(lrmf_pkg::REG_COLUMNS, 6);
		// The receiver holds off while a whole cloud is offered, so the block fills.
		-> hold_ev;
		queue_points(96);
		wait_drained();
		// Part of a second cloud, drained mid-cloud before the settings change.
		queue_points(30);
		wait_drained();

		send_idle_pct = 64;
		recv_idle_pct = 18;
		write_reg(lrmf_pkg::REG_RING_COUNT, 31);
		write_reg(lrmf_pkg::REG_COLUMNS, 4095);
		queue_points(40);
		wait_drained();
		write_reg(lrmf_pkg::REG_RING_COUNT, 3);
		write_reg(lrmf_pkg::REG_COLUMNS, 7);
		queue_points(63);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(lrmf_pkg::REG_RING_COUNT, 1);
		write_reg(lrmf_pkg::REG_COLUMNS, 5);
		queue_points(60);
		wait_drained();
		write_reg(lrmf_pkg::REG_RING_COUNT, 5);
		write_reg(lrmf_pkg::REG_COLUMNS, 9);
		queue_points(135);
		wait_drained();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
